/* sv/tlam_pkg.sv */
package tlam_pkg;

    // Widths and sizes
    localparam int PHASE_BITS       = 24;
    localparam int SAMPLE_BITS      = 24;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH);
    localparam int Q16_BITS         = 17;
    localparam int STEP_BITS        = 24;
    localparam int WAVE_BITS        = 3;
    localparam int PH_BITS          = 16;
    localparam int ACC_BITS         = SAMPLE_BITS + 1;
    localparam int MUL_STEPS        = Q16_BITS;
    localparam int CNT_BITS         = $clog2(MUL_STEPS);
    localparam int CFG_ADDR_BITS    = 4;
    localparam int CFG_DATA_BITS    = 32;

    // Sine index rounding: top address bits of the in-quadrant phase, rounded
    localparam int SINE_SHIFT = PHASE_BITS - 2 - SINE_ADDR_BITS;
    localparam logic [PHASE_BITS-2:0] SINE_HALF = (PHASE_BITS-1)'(1) << (SINE_SHIFT - 1);

    // Q16 constants
    localparam logic [Q16_BITS-1:0] Q16_ONE      = 17'd65536;
    localparam logic [Q16_BITS-1:0] Q16_HALF     = 17'd32768;
    localparam logic [17:0]         Q16_3HALF    = 18'd98304;
    localparam logic [PH_BITS-1:0]  PH_QUARTER   = 16'd16384;
    localparam logic [PH_BITS-1:0]  PH_HALF      = 16'd32768;
    localparam logic [PH_BITS-1:0]  PH_3QUARTER  = 16'd49152;
    localparam logic [PH_BITS-1:0]  PH_FALL      = 16'd31457;   // 0.48
    localparam logic [PH_BITS-1:0]  PH_RISE      = 16'd64225;   // 0.98
    localparam logic [17:0]         SLOPE_GAIN   = 18'd50;
    localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;

    // Taylor divisors (2n)(2n+1) for n = 1..8
    localparam int unsigned TAYLOR_DIV [0:7] = '{6, 20, 42, 72, 110, 156, 210, 272};

    // Register indexes
    localparam logic [1:0] REG_DEPTH      = 2'd0;
    localparam logic [1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [1:0] REG_WAVEFORM   = 2'd2;

    typedef enum logic [WAVE_BITS-1:0] {
        WAVE_SINE    = 3'd0,
        WAVE_TRI     = 3'd1,
        WAVE_SAW     = 3'd2,
        WAVE_INV_SAW = 3'd3,
        WAVE_SQUARE  = 3'd4,
        WAVE_SLOPED  = 3'd5
    } wave_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TABLE,
        ST_SHAPE,
        ST_GAIN,
        ST_GSUM,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [STEP_BITS-1:0] phase_step;
        logic [WAVE_BITS-1:0] waveform;
    } lfo_cfg_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic final_step;
    } mul_ctrl_t;

    typedef logic [SINE_TABLE_DEPTH-1:0][Q16_BITS-1:0] sine_rom_t;

    // One quarter-wave entry from a truncated Taylor series in Q30
    function automatic logic [Q16_BITS-1:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] v;
        x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 0; n < 8; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n];
            if (n % 2 == 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (64'(sum) + 64'd8192) >> 14;
        return (v > 64'(Q16_ONE)) ? Q16_ONE : v[Q16_BITS-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            rom[k] = sine_entry(k);
        return rom;
    endfunction

    localparam sine_rom_t             SINE_ROM = build_sine_rom();
    localparam logic [Q16_BITS-1:0]   SINE_TOP = sine_entry(SINE_TABLE_DEPTH);

endpackage

/* sv/tlam_channels_if.sv */
// Input frame channel
interface tlam_in_if;
    import tlam_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// Result frame channel
interface tlam_out_if;
    import tlam_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_result;
    logic signed [SAMPLE_BITS-1:0] right_result;

    modport source (output valid, output left_result, output right_result, input ready);
    modport sink   (input valid, input left_result, input right_result, output ready);
endinterface

/* sv/tlam_lfo.sv */
module tlam_lfo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tlam_pkg::lfo_cfg_t                 cfg,
    input  logic                               sample,
    output logic [tlam_pkg::Q16_BITS-1:0]      lfo
);
    import tlam_pkg::*;

    logic [PHASE_BITS-1:0]     phase_reg;
    logic [PHASE_BITS-1:0]     phase_next;
    logic [Q16_BITS-1:0]       tab_reg;
    logic                      lower_half_reg;
    logic [Q16_BITS-1:0]       wave_reg;
    logic [WAVE_BITS-1:0]      sel_reg;

    logic [PH_BITS-1:0]        ph;
    logic [1:0]                quad;
    logic [PHASE_BITS-2:0]     r_round;
    logic [SINE_ADDR_BITS:0]   idx;
    logic [SINE_ADDR_BITS:0]   idx_eff;
    logic [Q16_BITS-1:0]       tab_val;
    logic [17:0]               ph_wide;
    logic [17:0]               ph_dbl;
    logic [17:0]               wave_wide;
    logic [17:0]               sine_wide;

    // Advance the phase accumulator once per frame, wrapping at one
    assign phase_next = phase_reg + PHASE_BITS'(cfg.phase_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (sample)
            phase_reg <= phase_next;
    end

    // Nearest quarter-wave entry, mirrored in odd quadrants
    assign ph      = phase_reg[PHASE_BITS-1 -: PH_BITS];
    assign quad    = phase_reg[PHASE_BITS-1 -: 2];
    assign r_round = {1'b0, phase_reg[PHASE_BITS-3:0]} + SINE_HALF;
    assign idx     = r_round[PHASE_BITS-2:SINE_SHIFT];
    assign idx_eff = quad[0] ? ((SINE_ADDR_BITS+1)'(SINE_TABLE_DEPTH) - idx) : idx;
    assign tab_val = (idx_eff == (SINE_ADDR_BITS+1)'(SINE_TABLE_DEPTH)) ?
                     SINE_TOP : SINE_ROM[idx_eff[SINE_ADDR_BITS-1:0]];

    // Shapes other than sine, straight from the truncated Q16 phase
    assign ph_wide = 18'(ph);
    assign ph_dbl  = {1'b0, ph, 1'b0};

    always_comb
    begin
        wave_wide = '0;
        case (wave_t'(cfg.waveform))
            WAVE_TRI:
            begin
                if (ph < PH_QUARTER)
                    wave_wide = 18'(Q16_HALF) + ph_dbl;
                else if (ph < PH_3QUARTER)
                    wave_wide = Q16_3HALF - ph_dbl;
                else
                    wave_wide = ph_dbl - Q16_3HALF;
            end
            WAVE_SAW:
                wave_wide = (ph < PH_HALF) ? 18'(Q16_HALF) + ph_wide
                                           : ph_wide - 18'(Q16_HALF);
            WAVE_INV_SAW:
                wave_wide = (ph < PH_HALF) ? 18'(Q16_HALF) - ph_wide
                                           : Q16_3HALF - ph_wide;
            WAVE_SQUARE:
                wave_wide = (ph < PH_HALF) ? '0 : 18'(Q16_ONE);
            WAVE_SLOPED:
            begin
                if (ph < PH_FALL)
                    wave_wide = 18'(Q16_ONE);
                else if (ph < PH_HALF)
                    wave_wide = 18'(Q16_ONE) - 18'(ph - PH_FALL) * SLOPE_GAIN;
                else if (ph < PH_RISE)
                    wave_wide = '0;
                else
                    wave_wide = 18'(ph - PH_RISE) * SLOPE_GAIN;
            end
            default:
                wave_wide = '0;
        endcase
    end

    // Hold the looked-up values for the shaping cycle
    always_ff @(posedge clk)
    begin
        if (sample)
        begin
            tab_reg        <= tab_val;
            lower_half_reg <= quad[1];
            wave_reg       <= wave_wide[Q16_BITS-1:0];
            sel_reg        <= cfg.waveform;
        end
    end

    // Map the sine entry to 0..1 and pick the shape
    assign sine_wide = lower_half_reg ? (18'(Q16_ONE) - 18'(tab_reg))
                                      : (18'(Q16_ONE) + 18'(tab_reg));
    assign lfo = (wave_t'(sel_reg) == WAVE_SINE) ? sine_wide[Q16_BITS:1] : wave_reg;

endmodule

/* sv/tlam_serial_mul.sv */
module tlam_serial_mul (
    input  logic                                   clk,
    input  tlam_pkg::mul_ctrl_t                    ctrl,
    input  logic signed [tlam_pkg::ACC_BITS-1:0]   multiplicand,
    input  logic                                   mult_bit,
    output logic signed [tlam_pkg::ACC_BITS-1:0]   product
);
    import tlam_pkg::*;

    logic signed [ACC_BITS-1:0] acc_reg;
    logic signed [ACC_BITS-1:0] acc_next;
    logic signed [ACC_BITS-1:0] addend;
    logic signed [ACC_BITS:0]   sum_wide;

    // Add one partial product per cycle, LSB of the multiplier first;
    // drop one fraction bit on every step but the last
    assign addend   = mult_bit ? multiplicand : '0;
    assign sum_wide = {acc_reg[ACC_BITS-1], acc_reg} + {addend[ACC_BITS-1], addend};

    always_comb
    begin
        if (ctrl.clear)
            acc_next = '0;
        else if (ctrl.step)
            acc_next = ctrl.final_step ? sum_wide[ACC_BITS-1:0] : sum_wide[ACC_BITS:1];
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign product = acc_reg;

endmodule

/* sv/tremolo_lfo_amplitude_modulator_unit.sv */
// Stereo tremolo: both samples of a frame are scaled by 1 - depth + depth * lfo.
//
// in_frame carries one stereo frame per transfer (valid/ready); out_frame carries
// the scaled, saturated pair. The APB port sets depth (0x0), phase_step (0x4) and
// waveform_select (0x8); write it only while no frame is in flight.
//
// A frame passes through the table lookup, the shaping step, a bit-serial
// shift-add pass for depth * lfo, the gain sum, a second pass that scales both
// samples by the gain together and the load of the output register; both passes
// take one multiplier bit per cycle. A new frame is taken only once the last one
// has been loaded into the output register.
//
// The output register lets a new frame be taken while the last result waits. If
// the receiver stalls, the finished frame waits in its final cycle until the
// output register frees, and input ready stays low meanwhile.
//
// Reset puts the registers at depth one half, the default phase step and sine,
// zeroes the LFO phase and empties the output register. No clearing pass needed.
module tremolo_lfo_amplitude_modulator_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    tlam_in_if.sink                                  in_frame,
    tlam_out_if.source                               out_frame,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [tlam_pkg::CFG_ADDR_BITS-1:0]       paddr,
    input  logic [tlam_pkg::CFG_DATA_BITS-1:0]       pwdata,
    output logic [tlam_pkg::CFG_DATA_BITS-1:0]       prdata,
    output logic                                     pready
);
    import tlam_pkg::*;

    state_t                        state_reg;
    state_t                        state_next;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic [CNT_BITS-1:0]           cnt_next;
    logic [Q16_BITS-1:0]           bits_reg;
    logic [Q16_BITS-1:0]           bits_next;

    logic [Q16_BITS-1:0]           depth_reg;
    logic [STEP_BITS-1:0]          phase_step_reg;
    logic [WAVE_BITS-1:0]          waveform_reg;

    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] right_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic                          cfg_write;
    logic [1:0]                    cfg_index;
    logic [Q16_BITS-1:0]           depth_wr;
    logic                          in_xfer;
    logic                          out_load;
    logic                          lfo_sample;
    logic [Q16_BITS-1:0]           lfo_val;
    lfo_cfg_t                      lfo_cfg;
    mul_ctrl_t                     gain_ctrl;
    mul_ctrl_t                     scale_ctrl;
    logic                          last_step;
    logic signed [ACC_BITS-1:0]    gain_mcand;
    logic signed [ACC_BITS-1:0]    gain_prod;
    logic signed [ACC_BITS-1:0]    left_prod;
    logic signed [ACC_BITS-1:0]    right_prod;
    logic [17:0]                   gain_sum;

    // Clamp a product back to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] saturate(
        input logic signed [ACC_BITS-1:0] v);
        logic signed [SAMPLE_BITS-1:0] res;
        if (v[ACC_BITS-1] != v[ACC_BITS-2])
            res = v[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            res = v[SAMPLE_BITS-1:0];
        return res;
    endfunction

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];
    assign depth_wr  = (pwdata[Q16_BITS-1:0] > Q16_ONE) ? Q16_ONE : pwdata[Q16_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg      <= 17'd32768;
            phase_step_reg <= 24'd2796;
            waveform_reg   <= WAVE_SINE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEPTH:      depth_reg      <= depth_wr;
                REG_PHASE_STEP: phase_step_reg <= pwdata[STEP_BITS-1:0];
                REG_WAVEFORM:   waveform_reg   <= pwdata[WAVE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_DEPTH:      prdata = CFG_DATA_BITS'(depth_reg);
            REG_PHASE_STEP: prdata = CFG_DATA_BITS'(phase_step_reg);
            REG_WAVEFORM:   prdata = CFG_DATA_BITS'(waveform_reg);
            default:        prdata = '0;
        endcase
    end

    // Oscillator
    assign lfo_cfg.phase_step = phase_step_reg;
    assign lfo_cfg.waveform   = waveform_reg;

    tlam_lfo u_lfo (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (lfo_cfg),
        .sample (lfo_sample),
        .lfo    (lfo_val)
    );

    // Serial multipliers: one for depth * lfo, two for the samples
    assign gain_mcand = signed'(ACC_BITS'(depth_reg));

    tlam_serial_mul u_gain_mul (
        .clk          (clk),
        .ctrl         (gain_ctrl),
        .multiplicand (gain_mcand),
        .mult_bit     (bits_reg[0]),
        .product      (gain_prod)
    );

    tlam_serial_mul u_left_mul (
        .clk          (clk),
        .ctrl         (scale_ctrl),
        .multiplicand (ACC_BITS'(left_reg)),
        .mult_bit     (bits_reg[0]),
        .product      (left_prod)
    );

    tlam_serial_mul u_right_mul (
        .clk          (clk),
        .ctrl         (scale_ctrl),
        .multiplicand (ACC_BITS'(right_reg)),
        .mult_bit     (bits_reg[0]),
        .product      (right_prod)
    );

    assign gain_sum  = 18'(Q16_ONE) - 18'(depth_reg) + 18'(gain_prod[Q16_BITS-1:0]);
    assign last_step = (cnt_reg == CNT_BITS'(MUL_STEPS - 1));

    // Sequencer
    assign in_frame.ready = (state_reg == ST_IDLE);
    assign in_xfer        = in_frame.valid && in_frame.ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        lfo_sample = 1'b0;
        out_load   = 1'b0;
        gain_ctrl  = '0;
        scale_ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_TABLE;
            end
            ST_TABLE:
            begin
                lfo_sample = 1'b1;
                state_next = ST_SHAPE;
            end
            ST_SHAPE:
            begin
                bits_next       = lfo_val;
                cnt_next        = '0;
                gain_ctrl.clear = 1'b1;
                state_next      = ST_GAIN;
            end
            ST_GAIN:
            begin
                gain_ctrl.step       = 1'b1;
                gain_ctrl.final_step = last_step;
                bits_next            = bits_reg >> 1;
                cnt_next             = cnt_reg + 1'b1;
                if (last_step)
                    state_next = ST_GSUM;
            end
            ST_GSUM:
            begin
                bits_next        = gain_sum[Q16_BITS-1:0];
                cnt_next         = '0;
                scale_ctrl.clear = 1'b1;
                state_next       = ST_SCALE;
            end
            ST_SCALE:
            begin
                scale_ctrl.step       = 1'b1;
                scale_ctrl.final_step = last_step;
                bits_next             = bits_reg >> 1;
                cnt_next              = cnt_reg + 1'b1;
                if (last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_frame.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    // Capture the frame on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            left_reg  <= in_frame.left_sample;
            right_reg <= in_frame.right_sample;
        end
    end

    // Output register
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_frame.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= saturate(left_prod);
            right_out_reg <= saturate(right_prod);
        end
    end

    assign out_frame.valid        = out_valid_reg;
    assign out_frame.left_result  = left_out_reg;
    assign out_frame.right_result = right_out_reg;

    // Checks
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result appeared without a finished frame");

    a_gain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE && cnt_reg == '0) |-> (bits_reg <= Q16_ONE))
        else $error("gain above one");

    a_scale_after_gsum: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCALE && cnt_reg == '0) |-> $past(state_reg == ST_GSUM))
        else $error("sample pass started without a gain sum");

    a_no_load_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_frame.ready))
        else $error("output register overwritten while held");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import tlam_pkg::*;

    // Waveform codes with no shape behind them
    localparam logic [WAVE_BITS-1:0] WAVE_UNUSED_LO = 3'd6;
    localparam logic [WAVE_BITS-1:0] WAVE_UNUSED_HI = 3'd7;

    localparam int ONE_Q16   = 65536;
    localparam int HALF_Q16  = 32768;
    localparam int FALL_START = 31457;
    localparam int RISE_START = 64225;
    localparam int RANDOM_FRAMES = 1950;
    localparam int SETTLE_CYCLES = 45;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_CORNERS [7] = '{
        24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF,
        24'sh000001, 24'sh555555, 24'shAAAAAA
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } frame_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    tlam_in_if  in_frame ();
    tlam_out_if out_frame ();

    tremolo_lfo_amplitude_modulator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_frame  (in_frame),
        .out_frame (out_frame),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Mirror of the block's registers and oscillator
    logic [Q16_BITS-1:0]   depth_q;
    logic [STEP_BITS-1:0]  step_q;
    logic [WAVE_BITS-1:0]  wave_sel;
    logic [PHASE_BITS-1:0] phase_acc;
    logic [Q16_BITS-1:0]   sine_q [0:SINE_TABLE_DEPTH];

    frame_t pend_frames [$];
    frame_t exp_frames [$];

    int  n_queued   = 0;
    int  n_accepted = 0;
    int  n_checked  = 0;
    int  n_fail     = 0;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  in_taken = 1'b0;

    // Quarter-wave sine entry: Taylor series to x^17 in Q30, rounded to Q16
    function automatic logic [Q16_BITS-1:0] quarter_sine(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned divisor;
        longint unsigned v;
        longint          acc;
        int              n;
        x    = (64'd1686629713 * 64'(k)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (n = 1; n <= 8; n++) begin
            divisor = 64'((2 * n) * (2 * n + 1));
            term    = ((term * x2) >> 30) / divisor;
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        v = (unsigned'(acc) + 64'd8192) >> 14;
        return (v > 64'(ONE_Q16)) ? Q16_BITS'(ONE_Q16) : v[Q16_BITS-1:0];
    endfunction

    // Oscillator level in Q16 for the current waveform
    function automatic int lfo_level(input logic [PHASE_BITS-1:0] p);
        int              ph;
        int              t;
        logic [1:0]      quad;
        longint unsigned idx;
        ph   = int'(p[PHASE_BITS-1 -: PH_BITS]);
        quad = p[PHASE_BITS-1 -: 2];
        case (wave_sel)
            WAVE_SINE: begin
                idx = (64'(p[PHASE_BITS-3:0]) * SINE_TABLE_DEPTH
                       + (64'd1 << (PHASE_BITS - 3))) >> (PHASE_BITS - 2);
                if (idx > SINE_TABLE_DEPTH)
                    idx = SINE_TABLE_DEPTH;
                t = quad[0] ? int'(sine_q[SINE_TABLE_DEPTH - idx]) : int'(sine_q[idx]);
                return quad[1] ? (ONE_Q16 - t) >> 1 : (ONE_Q16 + t) >> 1;
            end
            WAVE_TRI: begin
                if (ph < 16384)
                    return HALF_Q16 + 2 * ph;
                if (ph < 49152)
                    return ONE_Q16 - 2 * (ph - 16384);
                return 2 * (ph - 49152);
            end
            WAVE_SAW:
                return (ph < HALF_Q16) ? HALF_Q16 + ph : ph - HALF_Q16;
            WAVE_INV_SAW:
                return (ph < HALF_Q16) ? HALF_Q16 - ph : 98304 - ph;
            WAVE_SQUARE:
                return (ph < HALF_Q16) ? 0 : ONE_Q16;
            WAVE_SLOPED: begin
                if (ph < FALL_START)
                    return ONE_Q16;
                if (ph < HALF_Q16)
                    return ONE_Q16 - 50 * (ph - FALL_START);
                if (ph < RISE_START)
                    return 0;
                return 50 * (ph - RISE_START);
            end
            default:
                return 0;
        endcase
    endfunction

    // Sample times gain, floored and saturated
    function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(
        input logic signed [SAMPLE_BITS-1:0] s,
        input longint                        gain
    );
        longint prod;
        prod = (longint'(s) * gain) >>> 16;
        if (prod > longint'(SAMPLE_MAX))
            prod = longint'(SAMPLE_MAX);
        if (prod < longint'(SAMPLE_MIN))
            prod = longint'(SAMPLE_MIN);
        return prod[SAMPLE_BITS-1:0];
    endfunction

    // Scale one frame by the tremolo gain and advance the oscillator
    function automatic frame_t tremolo_frame(input frame_t src);
        frame_t res;
        longint gain;
        gain = longint'(ONE_Q16) - longint'(depth_q)
               + ((longint'(depth_q) * longint'(lfo_level(phase_acc))) >>> 16);
        res.left  = apply_gain(src.left, gain);
        res.right = apply_gain(src.right, gain);
        phase_acc = phase_acc + step_q;
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        if ($urandom_range(7) == 0)
            return SAMPLE_CORNERS[$urandom_range(3)];
        return SAMPLE_BITS'($urandom);
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Input driver: hold each frame until its transfer, then advance
    always @(negedge clk)
    begin
        if (!rst_n)
            in_frame.valid <= 1'b0;
        else if (!in_frame.valid || in_taken)
        begin
            if (pend_frames.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_frame.valid        <= 1'b1;
                in_frame.left_sample  <= pend_frames[0].left;
                in_frame.right_sample <= pend_frames[0].right;
                void'(pend_frames.pop_front());
            end
            else
                in_frame.valid <= 1'b0;
        end
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        out_frame.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on input transfer, check on result transfer
    always @(posedge clk)
    begin
        frame_t src;
        frame_t want;
        in_taken <= in_frame.valid && in_frame.ready;
        if (rst_n)
        begin
            if (in_frame.valid && in_frame.ready)
            begin
                src.left  = in_frame.left_sample;
                src.right = in_frame.right_sample;
                exp_frames.push_back(tremolo_frame(src));
                n_accepted++;
            end
            if (out_frame.valid && out_frame.ready)
            begin
                if (exp_frames.size() == 0)
                begin
                    if (n_fail < 10)
                        $display("unexpected result L=%0d R=%0d",
                                 out_frame.left_result, out_frame.right_result);
                    n_fail++;
                end
                else
                begin
                    want = exp_frames.pop_front();
                    n_checked++;
                    if (out_frame.left_result !== want.left
                        || out_frame.right_result !== want.right)
                    begin
                        if (n_fail < 10)
                            $display("mismatch at result %0d: exp L=%0d R=%0d got L=%0d R=%0d",
                                     n_checked, want.left, want.right,
                                     out_frame.left_result, out_frame.right_result);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Register write: setup cycle, then access cycle
    task automatic reg_write(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_DEPTH:
                depth_q = (val[Q16_BITS-1:0] > Q16_BITS'(ONE_Q16)) ? Q16_BITS'(ONE_Q16)
                                                                   : val[Q16_BITS-1:0];
            REG_PHASE_STEP:
                step_q = val[STEP_BITS-1:0];
            REG_WAVEFORM:
                wave_sel = val[WAVE_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_tremolo(input logic [CFG_DATA_BITS-1:0] d,
                               input logic [CFG_DATA_BITS-1:0] s,
                               input logic [CFG_DATA_BITS-1:0] w);
        reg_write(REG_DEPTH, d);
        reg_write(REG_PHASE_STEP, s);
        reg_write(REG_WAVEFORM, w);
    endtask

    // Queue frames: corner samples for the directed part, random otherwise
    task automatic queue_frames(input int count, input bit corners);
        frame_t f;
        @(posedge clk);
        for (int k = 0; k < count; k++)
        begin
            if (corners)
            begin
                f.left  = SAMPLE_CORNERS[k % 7];
                f.right = SAMPLE_CORNERS[(k + 3) % 7];
            end
            else
            begin
                f.left  = pick_sample();
                f.right = pick_sample();
            end
            pend_frames.push_back(f);
            n_queued++;
        end
    endtask

    // Wait until every queued frame has gone in and its result has come out
    task automatic drain();
        do
            @(negedge clk);
        while (n_accepted != n_queued || n_checked != n_accepted);
    endtask

    // Random register value, sometimes with junk above the register width
    function automatic logic [CFG_DATA_BITS-1:0] with_junk(input logic [CFG_DATA_BITS-1:0] v,
                                                            input int bits);
        if ($urandom_range(3) == 0)
            return v | ($urandom << bits);
        return v;
    endfunction

    // Stimulus
    initial
    begin
        int done_random;
        int seg_len;
        logic [CFG_DATA_BITS-1:0] d;
        logic [CFG_DATA_BITS-1:0] s;

        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_frame.valid        = 1'b0;
        in_frame.left_sample  = '0;
        in_frame.right_sample = '0;
        out_frame.ready       = 1'b0;
        send_idle_pct         = 12;
        recv_idle_pct         = 58;
        depth_q               = Q16_BITS'(HALF_Q16);
        step_q                = 24'd2796;
        wave_sel              = WAVE_SINE;
        phase_acc             = '0;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
            sine_q[k] = quarter_sine(k);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register defaults straight out of reset, sine
        queue_frames(4, 1'b1);
        drain();
        // Depth above one is held at one; phase wraps on most frames
        set_tremolo(32'h1FFFF, 32'hF00000, WAVE_SQUARE);
        queue_frames(3, 1'b1);
        drain();
        set_tremolo(32'd65536, 32'hFFFFFF, WAVE_TRI);
        queue_frames(3, 1'b1);
        drain();
        set_tremolo(32'd0, 32'h2AAAAA, WAVE_SAW);
        queue_frames(3, 1'b1);
        drain();
        set_tremolo(32'd40000, 32'h555555, WAVE_INV_SAW);
        queue_frames(3, 1'b1);
        drain();
        set_tremolo(32'd65536, 32'h3E0000, WAVE_SLOPED);
        queue_frames(3, 1'b1);
        drain();
        // Unused codes give a flat gain of one minus depth
        set_tremolo(32'd65536, 32'd1, WAVE_UNUSED_LO);
        queue_frames(2, 1'b1);
        drain();
        set_tremolo(32'd20000, 32'd0, WAVE_UNUSED_HI);
        queue_frames(2, 1'b1);
        drain();

        // Random segments, each under its own register setting
        done_random = 0;
        while (done_random < RANDOM_FRAMES)
        begin
            case ($urandom_range(5))
                0:       d = 32'd0;
                1:       d = 32'd65536;
                2:       d = $urandom_range(131071, 65537);
                default: d = $urandom_range(65536);
            endcase
            case ($urandom_range(5))
                0:       s = 32'd0;
                1:       s = 32'hFFFFFF;
                2:       s = $urandom_range(4096, 1);
                default: s = {8'd0, 24'($urandom)};
            endcase
            set_tremolo(with_junk(d, Q16_BITS), with_junk(s, STEP_BITS),
                        with_junk($urandom_range(7), WAVE_BITS));
            @(posedge clk);
            if (done_random < RANDOM_FRAMES / 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 58;
            end
            else if (done_random < 2 * RANDOM_FRAMES / 3)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            seg_len = $urandom_range(90, 30);
            queue_frames(seg_len, 1'b0);
            drain();
            done_random += seg_len;
        end

        // Let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (exp_frames.size() != 0)
            n_fail++;
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* tremolo_lfo_amplitude_modulator_unit.f */
sv/tlam_pkg.sv
sv/tlam_channels_if.sv
sv/tlam_lfo.sv
sv/tlam_serial_mul.sv
sv/tremolo_lfo_amplitude_modulator_unit.sv
dv/testbench.sv
